// ===== src/ussd_pkg.sv =====
// Shared types and constants for the unsigned shift-subtract divider.
// Used by ussd_ctrl, ussd_datapath and the top level; depends on nothing.
package ussd_pkg;

    localparam int MAGNITUDE_WIDTH_DEFAULT = 64;
    localparam int SCALE_WIDTH = 8;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture a new operand transfer
        logic step_up;   // growing-multiple subtract step
        logic step_down; // restoring step with halving multiple
        logic publish;   // move finished result into output register
    } ussd_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic fits;        // partial remainder >= shifted divisor
        logic top_bit;     // shifted divisor MSB set
        logic div_zero;    // current divisor is zero
        logic finished;    // remainder or place value reached zero
        logic out_free;    // output register can take a result this cycle
    } ussd_status_t;

endpackage

// ===== src/ussd_ctrl.sv =====
// Sequencer for the shift-subtract divider: load, grow phase, shrink phase.
// Depends on ussd_pkg for the command and status structs.
module ussd_ctrl
    import ussd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         req_valid,
    output logic         req_stall,
    input  ussd_status_t status,
    output ussd_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_GROW = 2'd1;
    localparam logic [1:0] ST_SHRINK = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_GROW;
                end
            end
            ST_GROW:
            begin
                if (status.div_zero || !status.fits)
                begin
                    state_next = ST_SHRINK;
                end
                else
                begin
                    cmd.step_up = 1'b1;
                    if (status.top_bit)
                    begin
                        state_next = ST_SHRINK;
                    end
                end
            end
            ST_SHRINK:
            begin
                if (status.finished)
                begin
                    if (status.out_free)
                    begin
                        cmd.publish = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.step_down = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign req_stall = (state_reg != ST_IDLE);

endmodule

// ===== src/ussd_datapath.sv =====
// Datapath of the divider: remainder, divisor, place value and quotient
// registers, plus the output register. Depends on ussd_pkg.
module ussd_datapath
    import ussd_pkg::*;
#(
    parameter int MAGNITUDE_WIDTH = MAGNITUDE_WIDTH_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  ussd_cmd_t                  cmd,
    output ussd_status_t               status,
    input  logic [MAGNITUDE_WIDTH-1:0] dividend_magnitude,
    input  logic [MAGNITUDE_WIDTH-1:0] divisor_magnitude,
    input  logic                       dividend_negative,
    input  logic                       divisor_negative,
    input  logic [SCALE_WIDTH-1:0]     decimal_scale,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output logic [MAGNITUDE_WIDTH-1:0] quotient_magnitude,
    output logic [MAGNITUDE_WIDTH-1:0] remainder_magnitude,
    output logic                       quotient_negative,
    output logic                       remainder_negative,
    output logic [SCALE_WIDTH-1:0]     result_scale,
    output logic                       divide_by_zero
);

    localparam logic [MAGNITUDE_WIDTH-1:0] PLACE_ONE = MAGNITUDE_WIDTH'(1);

    logic [MAGNITUDE_WIDTH-1:0] rem_reg;
    logic [MAGNITUDE_WIDTH-1:0] rem_next;
    logic [MAGNITUDE_WIDTH-1:0] sdiv_reg;
    logic [MAGNITUDE_WIDTH-1:0] sdiv_next;
    logic [MAGNITUDE_WIDTH-1:0] place_reg;
    logic [MAGNITUDE_WIDTH-1:0] place_next;
    logic [MAGNITUDE_WIDTH-1:0] quot_reg;
    logic [MAGNITUDE_WIDTH-1:0] quot_next;
    logic                       qneg_reg;
    logic                       rneg_reg;
    logic [SCALE_WIDTH-1:0]     scale_reg;
    logic                       dbz_reg;

    logic [MAGNITUDE_WIDTH-1:0] out_quot_reg;
    logic [MAGNITUDE_WIDTH-1:0] out_rem_reg;
    logic                       out_qneg_reg;
    logic                       out_rneg_reg;
    logic [SCALE_WIDTH-1:0]     out_scale_reg;
    logic                       out_dbz_reg;
    logic                       rsp_valid_reg;
    logic                       rsp_valid_next;

    logic                       fits;
    logic [MAGNITUDE_WIDTH-1:0] diff;

    assign fits = (rem_reg >= sdiv_reg);
    assign diff = rem_reg - sdiv_reg;

    assign status.fits = fits;
    assign status.top_bit = sdiv_reg[MAGNITUDE_WIDTH-1];
    assign status.div_zero = dbz_reg;
    assign status.finished = (rem_reg == '0) || (place_reg == '0);
    assign status.out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        rem_next = rem_reg;
        sdiv_next = sdiv_reg;
        place_next = place_reg;
        quot_next = quot_reg;
        if (cmd.load)
        begin
            rem_next = dividend_magnitude;
            sdiv_next = divisor_magnitude;
            place_next = (divisor_magnitude == '0) ? '0 : PLACE_ONE;
            quot_next = '0;
        end
        else if (cmd.step_up)
        begin
            // place bits are disjoint, so OR is the add
            rem_next = diff;
            quot_next = quot_reg | place_reg;
            if (!sdiv_reg[MAGNITUDE_WIDTH-1])
            begin
                sdiv_next = {sdiv_reg[MAGNITUDE_WIDTH-2:0], 1'b0};
                place_next = {place_reg[MAGNITUDE_WIDTH-2:0], 1'b0};
            end
        end
        else if (cmd.step_down)
        begin
            if (fits)
            begin
                rem_next = diff;
                quot_next = quot_reg + place_reg;
            end
            sdiv_next = {1'b0, sdiv_reg[MAGNITUDE_WIDTH-1:1]};
            place_next = {1'b0, place_reg[MAGNITUDE_WIDTH-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            sdiv_reg <= '0;
            place_reg <= '0;
            quot_reg <= '0;
            dbz_reg <= 1'b0;
        end
        else
        begin
            rem_reg <= rem_next;
            sdiv_reg <= sdiv_next;
            place_reg <= place_next;
            quot_reg <= quot_next;
            if (cmd.load)
            begin
                dbz_reg <= (divisor_magnitude == '0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            qneg_reg <= dividend_negative ^ divisor_negative;
            rneg_reg <= dividend_negative;
            scale_reg <= decimal_scale;
        end
        if (cmd.publish)
        begin
            out_quot_reg <= quot_reg;
            out_rem_reg <= rem_reg;
            out_qneg_reg <= qneg_reg;
            out_rneg_reg <= rneg_reg;
            out_scale_reg <= scale_reg;
            out_dbz_reg <= dbz_reg;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.publish)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign quotient_magnitude = out_quot_reg;
    assign remainder_magnitude = out_rem_reg;
    assign quotient_negative = out_qneg_reg;
    assign remainder_negative = out_rneg_reg;
    assign result_scale = out_scale_reg;
    assign divide_by_zero = out_dbz_reg;

    a_publish_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |=> rsp_valid_reg)
        else $error("result not presented after publish");

    a_publish_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (!rsp_valid_reg || !rsp_stall))
        else $error("publish overwrote a pending result");

    a_remainder_never_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step_up || cmd.step_down) |=> (rem_reg <= $past(rem_reg)))
        else $error("partial remainder increased");

    a_shrink_halves_place: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step_down |=> (place_reg == ($past(place_reg) >> 1)))
        else $error("place value not halved");

    a_zero_divisor_no_place: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load && (divisor_magnitude == '0)) |=> (place_reg == '0))
        else $error("zero divisor left a nonzero place value");

endmodule

// ===== src/unsigned_shift_subtract_divider_unit.sv =====
// Top level of the unsigned shift-subtract divider.
// Instantiates ussd_ctrl and ussd_datapath; depends on ussd_pkg.
//
// Divides an unsigned MAGNITUDE_WIDTH-bit dividend by an unsigned divisor and returns
// the floor quotient and remainder; quotient sign is the XOR of the input signs, the
// remainder keeps the dividend sign and the decimal scale passes through. A zero
// divisor sets divide_by_zero with a zero quotient and the dividend as remainder.
// One operand transfer is in flight at a time. It passes through a load step, a grow
// phase with a doubling divisor (its last step may only find that it no longer fits),
// a shrink phase with a halving one, ending early when the remainder reaches zero, and
// a step that moves the result into the output register once that register is free.
// The result sits in an output register, so a new operand transfer is taken while the
// previous result waits on rsp_stall.
module unsigned_shift_subtract_divider_unit
    import ussd_pkg::*;
#(
    parameter int MAGNITUDE_WIDTH = MAGNITUDE_WIDTH_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_stall,
    input  logic [MAGNITUDE_WIDTH-1:0] dividend_magnitude,
    input  logic [MAGNITUDE_WIDTH-1:0] divisor_magnitude,
    input  logic                       dividend_negative,
    input  logic                       divisor_negative,
    input  logic [SCALE_WIDTH-1:0]     decimal_scale,
    output logic                       rsp_valid,
    input  logic                       rsp_stall,
    output logic [MAGNITUDE_WIDTH-1:0] quotient_magnitude,
    output logic [MAGNITUDE_WIDTH-1:0] remainder_magnitude,
    output logic                       quotient_negative,
    output logic                       remainder_negative,
    output logic [SCALE_WIDTH-1:0]     result_scale,
    output logic                       divide_by_zero
);

    ussd_cmd_t    cmd;
    ussd_status_t status;

    ussd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    ussd_datapath #(
        .MAGNITUDE_WIDTH (MAGNITUDE_WIDTH)
    ) u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .status              (status),
        .dividend_magnitude  (dividend_magnitude),
        .divisor_magnitude   (divisor_magnitude),
        .dividend_negative   (dividend_negative),
        .divisor_negative    (divisor_negative),
        .decimal_scale       (decimal_scale),
        .rsp_valid           (rsp_valid),
        .rsp_stall           (rsp_stall),
        .quotient_magnitude  (quotient_magnitude),
        .remainder_magnitude (remainder_magnitude),
        .quotient_negative   (quotient_negative),
        .remainder_negative  (remainder_negative),
        .result_scale        (result_scale),
        .divide_by_zero      (divide_by_zero)
    );

endmodule
